[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/mrbm_pkg.sv]
// ----------------------------------------------------------------------------
// mrbm_pkg
// Fixed widths and constants of the maximal rectangle core.
// ----------------------------------------------------------------------------
package mrbm_pkg;

  // Width of the row width configuration register.
  localparam int unsigned ROW_WIDTH_W   = 7;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 7'd64;

  // Width of the reported area and its saturation value.
  localparam int unsigned AREA_W   = 17;
  localparam logic [AREA_W-1:0] AREA_MAX = 17'h1FFFF;

endpackage

[rtl/core/mrbm_ram.sv]
// ----------------------------------------------------------------------------
// mrbm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mrbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/maximal_rectangle_binary_matrix_core.sv]
// Flow: a cell's column word is read as the cell is accepted and updated in the
//   forward state. A row-ending cell then runs a read/update pair per column from
//   right to left and an accumulate state; the last cell also passes a done state
//   before its result transaction is offered on the output.
// Input: a new cell waits until the block is idle; both passes share one column RAM.
// Reset: rst_n (synchronous, active low) clears the matrix and sets row width 64.
// ----------------------------------------------------------------------------
// maximal_rectangle_binary_matrix_core
// Streams a binary matrix one cell per transaction and reports the area of
// the largest rectangle made only of ones once the last cell is processed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module maximal_rectangle_binary_matrix_core #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port: row width, written whenever cfg_wr_en is high.
  input  logic                              cfg_wr_en,
  input  logic [mrbm_pkg::ROW_WIDTH_W-1:0]  cfg_row_width,
  // Input channel: one matrix cell per transaction.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cell_req,
  input  logic                              in_last_cell,
  // Output channel: one area per matrix.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mrbm_pkg::AREA_W-1:0]       out_max_area
);

  import mrbm_pkg::*;

  // Column index width, column count width (holds MAX_COLS itself) and height width.
  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CW = $clog2(MAX_COLS + 1);
  localparam int unsigned HW = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW = HW + CW;
  localparam int unsigned XW = (PW > AREA_W) ? PW : AREA_W;
  localparam int unsigned MW = (CW > ROW_WIDTH_W) ? CW : ROW_WIDTH_W;
  // Column word: {cell, height, left wall + 1, right wall}.
  localparam int unsigned WORD_W = 1 + HW + 2 * CW;

  // The sequencer walks each cell through a read and an update cycle, and at a
  // row end runs the same read/update pair from right to left over the row.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FWD    = 6'b000010,
    S_CL_RD  = 6'b000100,
    S_CL_UPD = 6'b001000,
    S_CL_ACC = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [ROW_WIDTH_W-1:0]   row_width_r, row_width_nxt;
  logic [CW-1:0]            col_idx_r, col_idx_nxt;
  logic [AW-1:0]            col_j_r, col_j_nxt;
  logic                     cell_r, cell_nxt;
  logic                     last_r, last_nxt;
  logic [CW-1:0]            nl1_r, nl1_nxt;     // nearest left zero of the row, plus one
  logic [CW-1:0]            nr_r, nr_nxt;       // nearest right zero of the row
  logic [AW-1:0]            cl_idx_r, cl_idx_nxt;
  logic [AREA_W-1:0]        best_r, best_nxt;
  logic [PW-1:0]            prod_r, prod_nxt;
  logic                     prod_vld_r, prod_vld_nxt;
  logic [MAX_COLS-1:0]      col_vld_r, col_vld_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [AREA_W-1:0]        out_area_r, out_area_nxt;

  logic [CW-1:0]            eff_w;
  logic [MW-1:0]            rw_x;
  logic [CW-1:0]            j_full;
  logic [AW-1:0]            j_cur;
  logic                     in_fire;

  logic                     ram_wr_en;
  logic [AW-1:0]            ram_wr_addr;
  logic [WORD_W-1:0]        ram_wr_data;
  logic [AW-1:0]            ram_rd_addr;
  logic [WORD_W-1:0]        ram_rd_data;

  logic [AW-1:0]            rd_idx;
  logic                     rd_vld;
  logic                     rd_cell;
  logic [HW-1:0]            rd_h;
  logic [CW-1:0]            rd_lp1;
  logic [CW-1:0]            rd_r;

  logic [HW-1:0]            fw_h;
  logic [CW-1:0]            fw_lp1;
  logic [CW-1:0]            cl_r;
  logic [CW-1:0]            cl_span;
  logic [XW-1:0]            prod_x;
  logic [AREA_W-1:0]        area_sat;
  logic                     out_free;

  // Effective row width: zero acts as one, anything above MAX_COLS is clamped.
  always_comb begin
    rw_x = MW'(row_width_r);
    if (row_width_r == '0) begin
      eff_w = CW'(1);
    end else if (rw_x > MW'(MAX_COLS)) begin
      eff_w = CW'(MAX_COLS);
    end else begin
      eff_w = rw_x[CW-1:0];
    end
  end

  assign j_full  = (col_idx_r >= eff_w) ? (eff_w - CW'(1)) : col_idx_r;
  assign j_cur   = j_full[AW-1:0];

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // One RAM holds every column word. The read address is the incoming column
  // while idle and the backward pass counter otherwise.
  assign ram_rd_addr = (state_r == S_IDLE) ? j_cur : cl_idx_r;

  mrbm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_COLS)
  ) u_col_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // A column not written since the last clear reads as its reset contents:
  // zero height, left wall at minus one and right wall at the row width.
  assign rd_idx = (state_r == S_FWD) ? col_j_r : cl_idx_r;
  assign rd_vld = col_vld_r[rd_idx];

  always_comb begin
    if (rd_vld) begin
      {rd_cell, rd_h, rd_lp1, rd_r} = ram_rd_data;
    end else begin
      rd_cell = 1'b0;
      rd_h    = '0;
      rd_lp1  = '0;
      rd_r    = eff_w;
    end
  end

  // Forward update: pull the left wall in to the nearest zero on the left,
  // then grow or reset the column height.
  always_comb begin
    fw_lp1 = (rd_lp1 > nl1_r) ? rd_lp1 : nl1_r;
    fw_h   = rd_h;
    if (cell_r) begin
      if (rd_h < HW'(MAX_ROWS)) begin
        fw_h = rd_h + HW'(1);
      end
    end else begin
      fw_h   = '0;
      fw_lp1 = '0;
    end
  end

  // Backward update: pull the right wall in to the nearest zero on the right;
  // a zero cell resets its own right wall to the row width.
  always_comb begin
    cl_r = (nr_r < rd_r) ? nr_r : rd_r;
    if (!rd_cell) begin
      cl_r = eff_w;
    end
    cl_span = (cl_r >= rd_lp1) ? (cl_r - rd_lp1) : '0;
  end

  // Area of the previous column, registered after the multiplier.
  assign prod_x   = XW'(prod_r);
  assign area_sat = (prod_x > XW'(AREA_MAX)) ? AREA_MAX : prod_x[AREA_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    row_width_nxt = row_width_r;
    col_idx_nxt   = col_idx_r;
    col_j_nxt     = col_j_r;
    cell_nxt      = cell_r;
    last_nxt      = last_r;
    nl1_nxt       = nl1_r;
    nr_nxt        = nr_r;
    cl_idx_nxt    = cl_idx_r;
    best_nxt      = best_r;
    prod_nxt      = prod_r;
    prod_vld_nxt  = 1'b0;
    col_vld_nxt   = col_vld_r;
    out_valid_nxt = out_valid_r;
    out_area_nxt  = out_area_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = cl_idx_r;
    ram_wr_data   = {rd_cell, rd_h, rd_lp1, cl_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // The product of the previous update cycle is folded into the best area.
    if (prod_vld_r && (area_sat > best_r)) begin
      best_nxt = area_sat;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          col_j_nxt = j_cur;
          cell_nxt  = in_cell_req;
          last_nxt  = in_last_cell;
          state_nxt = S_FWD;
        end
      end
      S_FWD: begin
        ram_wr_en            = 1'b1;
        ram_wr_addr          = col_j_r;
        ram_wr_data          = {cell_r, fw_h, fw_lp1, rd_r};
        col_vld_nxt[col_j_r] = 1'b1;
        if (!cell_r) begin
          nl1_nxt = CW'(col_j_r) + CW'(1);
        end
        col_idx_nxt = CW'(col_j_r) + CW'(1);
        if ((col_idx_nxt >= eff_w) || last_r) begin
          cl_idx_nxt = col_j_r;
          nr_nxt     = eff_w;
          state_nxt  = S_CL_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CL_RD: begin
        state_nxt = S_CL_UPD;
      end
      S_CL_UPD: begin
        ram_wr_en    = 1'b1;
        prod_nxt     = PW'(rd_h) * PW'(cl_span);
        prod_vld_nxt = 1'b1;
        if (!rd_cell) begin
          nr_nxt = CW'(cl_idx_r);
        end
        if (cl_idx_r == '0) begin
          state_nxt = S_CL_ACC;
        end else begin
          cl_idx_nxt = cl_idx_r - AW'(1);
          state_nxt  = S_CL_RD;
        end
      end
      S_CL_ACC: begin
        col_idx_nxt = '0;
        nl1_nxt     = '0;
        state_nxt   = last_r ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        // Hand the area over and clear the matrix once the output is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_area_nxt  = best_r;
          best_nxt      = '0;
          col_vld_nxt   = '0;
          col_idx_nxt   = '0;
          nl1_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A row width write starts a new matrix.
    if (cfg_wr_en) begin
      row_width_nxt = cfg_row_width;
      best_nxt      = '0;
      col_vld_nxt   = '0;
      col_idx_nxt   = '0;
      nl1_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_width_r <= ROW_WIDTH_RST;
      col_idx_r   <= '0;
      nl1_r       <= '0;
      nr_r        <= '0;
      best_r      <= '0;
      prod_vld_r  <= 1'b0;
      col_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_width_r <= row_width_nxt;
      col_idx_r   <= col_idx_nxt;
      nl1_r       <= nl1_nxt;
      nr_r        <= nr_nxt;
      best_r      <= best_nxt;
      prod_vld_r  <= prod_vld_nxt;
      col_vld_r   <= col_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_j_r    <= col_j_nxt;
    cell_r     <= cell_nxt;
    last_r     <= last_nxt;
    cl_idx_r   <= cl_idx_nxt;
    prod_r     <= prod_nxt;
    out_area_r <= out_area_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_max_area = out_area_r;

  `ASSERT_NEVER(a_col_idx_range, clk, rst_n, col_idx_r > eff_w, "column index beyond row width")
  `ASSERT_CLK(a_close_valid, clk, rst_n, (state_r == S_CL_UPD) |-> col_vld_r[cl_idx_r], "backward pass reached a column not written in this row")
  `ASSERT_CLK(a_fwd_next, clk, rst_n, (state_r == S_FWD) |=> ((state_r == S_IDLE) || (state_r == S_CL_RD)), "forward update left to an unexpected state")
  `ASSERT_CLK(a_clear_on_result, clk, rst_n, ($rose(out_valid_r) && !$past(cfg_wr_en)) |-> ((best_r == '0) && (col_idx_r == '0) && (col_vld_r == '0)), "matrix state not cleared with the result")

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the maximal rectangle core. A built-in model of the
// column heights and walls predicts the area of each matrix. The bench runs a
// short table of directed cases, then random matrices over many row widths,
// with random idle cycles on both channels and forced back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import mrbm_pkg::*;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 1024;
  // Random cells sent after the directed table, not counting the tall matrix.
  localparam int RAND_CELLS  = 580;
  // Long enough for a full 64-column row-end pass, so it covers any work left
  // in flight once the last expected result has come out.
  localparam int DRAIN       = 200;
  // Length of the forced output hold-off, in cycles.
  localparam int HOLD_CYCLES = 400;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int LIMIT       = 3000;
  // Rows in the tall matrix; more than MAX_ROWS so heights must saturate.
  localparam int TALL_ROWS   = 1030;

  typedef enum bit {ROW_CELL, ROW_CFG} row_kind_t;

  // One line of the directed table: either a row width write or one cell.
  // Where the area is obvious it is typed in; otherwise the model supplies it.
  typedef struct {
    row_kind_t              kind;
    logic [ROW_WIDTH_W-1:0] width;
    bit                     val;
    bit                     last;
    bit                     typed;
    logic [AREA_W-1:0]      area;
  } dir_row_t;

  localparam int DIR_ROWS = 24;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // Reset width of 64: a lone zero ends the matrix early, area is zero.
    '{ROW_CELL, 7'd0,   1'b0, 1'b1, 1'b1, 17'd0},
    // A lone one, again ended early. Its right wall stays at the row width,
    // so the span is the full 64 columns.
    '{ROW_CELL, 7'd0,   1'b1, 1'b1, 1'b1, 17'd64},
    // A width of zero behaves as a single column: three ones stack to area 3,
    // and the last cell also lands exactly on a row end.
    '{ROW_CFG,  7'd0,   1'b0, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b1, 1'b1, 17'd3},
    // The largest register value behaves as 64 columns. A zero then a one,
    // ended early: the one spans from the zero to the row width, 63 columns.
    '{ROW_CFG,  7'd127, 1'b0, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b0, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b1, 1'b1, 17'd63},
    // Two columns, three rows, with a zero that splits the middle row.
    '{ROW_CFG,  7'd2,   1'b0, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b0, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b1, 1'b0, 17'd0},
    // Three columns, two rows, with a left wall in the first row.
    '{ROW_CFG,  7'd3,   1'b0, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b0, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b0, 1'b0, 17'd0},
    '{ROW_CELL, 7'd0,   1'b1, 1'b1, 1'b0, 17'd0},
    // A row width of 1 after a width of 3, with the last cell at the row end.
    '{ROW_CFG,  7'd1,   1'b0, 1'b0, 1'b0, 17'd0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [ROW_WIDTH_W-1:0] cfg_row_width;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_cell_req;
  logic                   in_last_cell;
  logic                   out_valid;
  logic                   out_ready;
  logic [AREA_W-1:0]      out_max_area;

  maximal_rectangle_binary_matrix_core #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_row_width (cfg_row_width),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cell_req   (in_cell_req),
    .in_last_cell  (in_last_cell),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_max_area  (out_max_area)
  );

  // Clock with a period of 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Area model. It keeps its own copy of the row width register and of the
  // per-column state: run height of ones, nearest left zero and nearest right
  // zero. Each cell updates its column going forward; a row end runs a pass
  // from right to left that fixes the right walls and the best area so far.
  // --------------------------------------------------------------------------
  logic [ROW_WIDTH_W-1:0] width_reg;
  logic [10:0]            col_height [MAX_COLS];
  int                     left_edge  [MAX_COLS];
  int                     right_edge [MAX_COLS];
  bit                     row_bits   [MAX_COLS];
  int                     col_pos;
  int                     zero_left;
  logic [AREA_W-1:0]      best_area;

  // Expected areas, oldest first.
  logic [AREA_W-1:0]      area_q [$];

  // The register value as the block uses it: zero acts as one column and
  // anything above the maximum acts as the maximum.
  function automatic int rect_cols();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return int'(width_reg);
  endfunction

  function automatic void rect_clear();
    for (int j = 0; j < MAX_COLS; j++) begin
      col_height[j] = '0;
      left_edge[j]  = -1;
      right_edge[j] = rect_cols();
      row_bits[j]   = 1'b0;
    end
    col_pos   = 0;
    zero_left = -1;
    best_area = '0;
  endfunction

  // Right-to-left pass over the cells received in the current row. The right
  // boundary starts at the row width even when the row was cut short.
  function automatic void rect_close_row();
    int     w;
    int     near_right;
    int     span;
    longint prod;
    w = rect_cols();
    near_right = w;
    for (int j = col_pos - 1; j >= 0; j--) begin
      if (near_right < right_edge[j]) right_edge[j] = near_right;
      if (!row_bits[j]) begin
        near_right    = j;
        right_edge[j] = w;
      end
      span = right_edge[j] - left_edge[j] - 1;
      if (span < 0) span = 0;
      prod = longint'(col_height[j]) * longint'(span);
      if (prod > longint'(AREA_MAX)) prod = longint'(AREA_MAX);
      if (prod > longint'(best_area)) best_area = prod[AREA_W-1:0];
    end
    col_pos   = 0;
    zero_left = -1;
  endfunction

  // Applies one cell; on the last cell it hands back the area and starts a
  // fresh matrix.
  function automatic void rect_cell(input bit cval, input bit last,
                                    output bit has_area,
                                    output logic [AREA_W-1:0] area);
    int w;
    int j;
    w = rect_cols();
    j = col_pos;
    if (j >= w) j = w - 1;
    if (zero_left > left_edge[j]) left_edge[j] = zero_left;
    if (cval) begin
      // Heights stop growing at the row limit.
      if (col_height[j] < MAX_ROWS) col_height[j] = col_height[j] + 1'b1;
    end else begin
      col_height[j] = '0;
      left_edge[j]  = -1;
      zero_left     = j;
    end
    row_bits[j] = cval;
    col_pos     = j + 1;
    if (col_pos >= w || last) rect_close_row();
    has_area = last;
    area     = best_area;
    if (last) rect_clear();
  endfunction

  // --------------------------------------------------------------------------
  // Shared bench state.
  // --------------------------------------------------------------------------
  bit tx_idle;        // sender inserts random gaps
  bit rx_idle;        // receiver inserts random stalls
  bit hold_req;       // ask the receiver for one long hold-off
  int long_holds;
  int cells_sent;
  int areas_seen;
  int width_writes;
  int fail_count;
  int quiet_cycles;
  logic [AREA_W-1:0] area_exp;

  // --------------------------------------------------------------------------
  // Sender side. Inputs change only at the falling edge, and acceptance is
  // seen at the rising edge where valid and ready are both high. Valid stays
  // up with a steady payload until the transaction goes through; when no gap
  // is drawn the next cell follows back to back.
  // --------------------------------------------------------------------------
  task automatic send_cell(input bit cval, input bit last, input bit typed,
                           input logic [AREA_W-1:0] typed_area);
    int unsigned pick;
    int unsigned gap;
    bit          has_area;
    logic [AREA_W-1:0] area;
    gap = 0;
    if (tx_idle) begin
      pick = $urandom_range(0, 99);
      if (pick >= 94)      gap = $urandom_range(8, 40);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     = 1'b1;
    in_cell_req  = cval;
    in_last_cell = last;
    do @(posedge clk); while (!in_ready);
    // The transaction is accepted at this edge; the model follows it here.
    rect_cell(cval, last, has_area, area);
    if (has_area) area_q.push_back(typed ? typed_area : area);
    cells_sent++;
  endtask

  // Stop offering cells and wait for every expected area to come out.
  task automatic wait_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (area_q.size() != 0) @(posedge clk);
  endtask

  // The register is written only while the block is idle: all results are
  // out, and a row-end pass that produces no result has had time to finish.
  task automatic write_row_width(input logic [ROW_WIDTH_W-1:0] value);
    wait_results();
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
    cfg_wr_en     = 1'b1;
    cfg_row_width = value;
    @(posedge clk);
    width_reg = value;
    rect_clear();
    @(negedge clk);
    cfg_wr_en = 1'b0;
    width_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver side. Ready changes at the falling edge. Stalls are mostly short
  // with an occasional long one, and a requested hold-off keeps ready low
  // for HOLD_CYCLES so the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    int unsigned pick;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
        long_holds++;
      end
      if (stall_left != 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (!rx_idle) begin
        out_ready = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          out_ready = 1'b1;
        end else begin
          out_ready  = 1'b0;
          stall_left = (pick < 96) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each accepted area is compared with the oldest expected
  // one. The first ten problems are printed, the rest only counted.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      areas_seen++;
      if (area_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Unexpected result transaction: max_area %0d", out_max_area);
      end else begin
        area_exp = area_q.pop_front();
        if (out_max_area !== area_exp) begin
          fail_count++;
          if (fail_count <= 10)
            $display("max_area mismatch: expected %0d, got %0d", area_exp, out_max_area);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", LIMIT);
      $display("FAIL maximal_rectangle_binary_matrix_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int          phase;
    int          phase_end;
    int          rand_cells;
    int          cols;
    int          rows;
    int unsigned dens;
    int          lastpos;
    int unsigned pick;
    logic [ROW_WIDTH_W-1:0] wval;
    bit          cval;
    bit          last;

    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_row_width = '0;
    in_valid      = 1'b0;
    in_cell_req   = 1'b0;
    in_last_cell  = 1'b0;
    tx_idle       = 1'b0;
    rx_idle       = 1'b0;
    hold_req      = 1'b0;
    long_holds    = 0;
    cells_sent    = 0;
    areas_seen    = 0;
    width_writes  = 0;
    fail_count    = 0;
    quiet_cycles  = 0;
    rand_cells    = 0;

    // Model state after reset: 64 columns and an empty matrix.
    width_reg = ROW_WIDTH_RST;
    rect_clear();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table, with both sides always ready.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_CFG)
        write_row_width(dir_tab[i].width);
      else
        send_cell(dir_tab[i].val, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].area);
    end
    // The last table line left a single column: the last cell is its row end.
    send_cell(1'b1, 1'b1, 1'b1, 17'd1);

    // Random phases. Each one writes a new row width and then streams whole
    // matrices of random content. The first few phases pin the extremes.
    phase = 0;
    while (rand_cells < RAND_CELLS) begin
      case (phase)
        0: wval = 7'd1;
        1: wval = 7'd0;
        2: wval = 7'd127;
        3: wval = 7'd64;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 6)       wval = 7'($urandom_range(1, 8));
          else if (pick < 8)  wval = 7'($urandom_range(9, 40));
          else if (pick == 8) wval = 7'($urandom_range(41, 64));
          else wval = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom_range(65, 127));
        end
      endcase
      write_row_width(wval);
      cols = rect_cols();

      // Phase 0 runs with no idling at all and phase 1 with no sender gaps; the rest is drawn at random.
      tx_idle   = (phase != 0) && (phase != 1) && ($urandom_range(0, 3) != 0);
      rx_idle   = (phase != 0) && ($urandom_range(0, 3) != 0);
      phase_end = rand_cells + ((cols > 16) ? 150 : 100);

      // A single column of ones taller than the height limit: heights must
      // stop at the limit, so the area is the limit itself.
      if (phase == 0) begin
        for (int r = 0; r < TALL_ROWS; r++)
          send_cell(1'b1, r == TALL_ROWS - 1, 1'b1, 17'(MAX_ROWS));
      end

      // One-column matrices give a result every few cells, so a long output
      // hold-off here makes the block back up while cells keep coming.
      if (phase == 1) hold_req = 1'b1;

      while (rand_cells < phase_end) begin
        if (cols <= 4)       rows = int'($urandom_range(1, 10));
        else if (cols <= 16) rows = int'($urandom_range(1, 5));
        else                 rows = int'($urandom_range(1, 3));
        pick = $urandom_range(0, 9);
        if (pick == 0)      dens = 0;
        else if (pick == 1) dens = 100;
        else if (pick == 2) dens = $urandom_range(10, 50);
        else                dens = $urandom_range(60, 95);
        // Most matrices end on a full row; some end part way through it.
        lastpos = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, cols - 1)) : cols - 1;
        for (int r = 0; r < rows; r++) begin
          for (int c = 0; c < cols; c++) begin
            if (r == rows - 1 && c > lastpos) break;
            cval = ($urandom_range(0, 99) < dens);
            last = (r == rows - 1) && (c == lastpos);
            send_cell(cval, last, 1'b0, '0);
            rand_cells++;
          end
        end
        // In the full-width phase the sender sometimes pauses after a matrix until
        // every expected area has come out before carrying on.
        if (phase == 3 && rand_cells < phase_end && $urandom_range(0, 1) == 0)
          wait_results();
      end
      phase++;
    end

    wait_results();
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d cells over %0d row width settings; checked %0d areas.",
             cells_sent, width_writes, areas_seen);
    $display("Included saturated heights, early last cells and %0d long output hold-off(s).",
             long_holds);
    if (fail_count == 0 && area_q.size() == 0) begin
      $display("PASS maximal_rectangle_binary_matrix_core");
    end else begin
      $display("FAIL maximal_rectangle_binary_matrix_core");
    end
    $finish;
  end

endmodule
